FILE: design/bpq_pkg.sv
package bpq_pkg;

    // Store geometry
    localparam int NUM_LEVELS  = 32;
    localparam int LEVEL_DEPTH = 16;

    localparam int ID_W      = 4;
    localparam int PRIO_W    = 5;
    localparam int MAP_W     = 32;
    localparam int LVL_IDX_W = $clog2(NUM_LEVELS);
    localparam int PTR_W     = $clog2(LEVEL_DEPTH);
    localparam int CNT_W     = $clog2(LEVEL_DEPTH + 1);
    localparam int SLOTS     = NUM_LEVELS * LEVEL_DEPTH;
    localparam int ADDR_W    = $clog2(SLOTS);

    typedef enum logic [1:0] {
        REQ_ENQ = 2'd0,
        REQ_POP = 2'd1,
        REQ_REM = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } t_status;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic    load_req;
        logic    enq_commit;
        logic    pop_read;
        logic    pop_commit;
        logic    empty_res;
        logic    st_we;
        t_status st;
        logic    scan_start;
        logic    scan_read;
        logic    scan_next;
        logic    shift_read;
        logic    shift_write;
        logic    rm_commit;
        logic    out_load;
    } t_dp_cmd;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic [1:0] req_type;
        logic       lvl_ok;
        logic       full;
        logic       empty;
        logic       scan_end;
        logic       match;
        logic       shift_end;
        logic       out_free;
    } t_dp_stat;

    // Highest set bit of the ready map
    function automatic logic [LVL_IDX_W-1:0] top_level(input logic [NUM_LEVELS-1:0] map);
        logic [LVL_IDX_W-1:0] top;
        top = '0;
        for (int p = 0; p < NUM_LEVELS; p++) begin
            if (map[p]) begin
                top = LVL_IDX_W'(p);
            end
        end
        return top;
    endfunction

    // Ring position plus offset, offset below the depth
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(ptr) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(LEVEL_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(LEVEL_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    // Flat slot address of a level and ring position
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [LVL_IDX_W-1:0] lvl,
                                                    input logic [PTR_W-1:0] pos);
        return ADDR_W'(lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(pos);
    endfunction

endpackage

FILE: design/bpq_if.sv
interface bpq_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [3:0] thread_id;
    logic [4:0] priority_req;

    modport source (output valid, output req_type, output thread_id, output priority_req,
                    input ready);
    modport sink   (input valid, input req_type, input thread_id, input priority_req,
                    output ready);
endinterface

interface bpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  out_thread_id;
    logic [4:0]  out_priority;
    logic [1:0]  status;
    logic [31:0] ready_map;

    modport source (output valid, output out_thread_id, output out_priority, output status,
                    output ready_map, input ready);
    modport sink   (input valid, input out_thread_id, input out_priority, input status,
                    input ready_map, output ready);
endinterface

FILE: design/bitmap_priority_ready_queue.sv
// Channel   Dir  Handshake     Payload
// i_req     in   valid/ready   req_type[1:0] thread_id[3:0] priority_req[4:0]
// o_rsp     out  valid/ready   out_thread_id[3:0] out_priority[4:0] status[1:0]
//                              ready_map[31:0]
// cfg       in   i_cfg_we      i_cfg_data[3:0] (idle thread id)
//
// One request at a time; all slot traffic goes through the single write port and
// the single read port of the slot RAM. Enqueue and any request rejected at decode
// go from decode straight to the done state, a pop reads the head slot first; a
// remove scans its level for the id and, on a hit, shifts each later entry down one slot.
// A request is accepted while an earlier result still sits in the output
// register; a finished result waits in the sequencer until that register frees.
// Synchronous active-low reset empties every level and clears the idle id.
module bitmap_priority_ready_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [3:0]       i_cfg_data,
    bpq_req_if.sink          i_req,
    bpq_rsp_if.source        o_rsp
);

    bpq_pkg::t_dp_cmd  w_cmd;
    bpq_pkg::t_dp_stat w_stat;
    logic              w_req_ready;

    assign i_req.ready = w_req_ready;

    bpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_stat      (w_stat),
        .o_req_ready (w_req_ready),
        .o_cmd       (w_cmd)
    );

    bpq_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_req_type      (i_req.req_type),
        .i_thread_id     (i_req.thread_id),
        .i_priority_req  (i_req.priority_req),
        .i_out_ready     (o_rsp.ready),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_out_valid     (o_rsp.valid),
        .o_out_thread_id (o_rsp.out_thread_id),
        .o_out_priority  (o_rsp.out_priority),
        .o_status        (o_rsp.status),
        .o_ready_map     (o_rsp.ready_map)
    );

endmodule

FILE: design/bpq_ram.sv
module bpq_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bpq_datapath.sv
module bpq_datapath (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [3:0]              i_cfg_data,
    input  logic [1:0]              i_req_type,
    input  logic [3:0]              i_thread_id,
    input  logic [4:0]              i_priority_req,
    input  logic                    i_out_ready,
    input  bpq_pkg::t_dp_cmd        i_cmd,
    output bpq_pkg::t_dp_stat       o_stat,
    output logic                    o_out_valid,
    output logic [3:0]              o_out_thread_id,
    output logic [4:0]              o_out_priority,
    output logic [1:0]              o_status,
    output logic [31:0]             o_ready_map
);

    logic [3:0]                       r_idle_id;
    logic [1:0]                       r_req_type;
    logic [3:0]                       r_id;
    logic                             r_lvl_ok;
    logic [bpq_pkg::LVL_IDX_W-1:0]    r_sel;
    logic [bpq_pkg::CNT_W-1:0]        r_idx;

    logic [bpq_pkg::PTR_W-1:0]        r_head [bpq_pkg::NUM_LEVELS];
    logic [bpq_pkg::PTR_W-1:0]        r_tail [bpq_pkg::NUM_LEVELS];
    logic [bpq_pkg::CNT_W-1:0]        r_count [bpq_pkg::NUM_LEVELS];
    logic [bpq_pkg::NUM_LEVELS-1:0]   r_map;

    logic [3:0]                       r_res_id;
    logic [4:0]                       r_res_lvl;
    logic [1:0]                       r_res_st;

    logic                             r_out_valid;
    logic [3:0]                       r_out_id;
    logic [4:0]                       r_out_lvl;
    logic [1:0]                       r_out_st;
    logic [31:0]                      r_out_map;

    logic                             w_lvl_ok;
    logic [bpq_pkg::LVL_IDX_W-1:0]    w_sel;
    logic [bpq_pkg::PTR_W-1:0]        w_head;
    logic [bpq_pkg::PTR_W-1:0]        w_tail;
    logic [bpq_pkg::CNT_W-1:0]        w_count;
    logic [bpq_pkg::CNT_W-1:0]        w_idx_inc;
    logic                             w_we;
    logic [bpq_pkg::ADDR_W-1:0]       w_waddr;
    logic [3:0]                       w_wdata;
    logic                             w_re;
    logic [bpq_pkg::ADDR_W-1:0]       w_raddr;
    logic [3:0]                       w_rdata;
    logic                             w_out_free;

    // Level check and level pick at request time
    assign w_lvl_ok = (32'(i_priority_req) < 32'(bpq_pkg::NUM_LEVELS));
    always_comb begin
        if (i_req_type == bpq_pkg::REQ_POP) begin
            w_sel = bpq_pkg::top_level(r_map);
        end else if (w_lvl_ok) begin
            w_sel = i_priority_req[bpq_pkg::LVL_IDX_W-1:0];
        end else begin
            w_sel = '0;
        end
    end

    assign w_head    = r_head[r_sel];
    assign w_tail    = r_tail[r_sel];
    assign w_count   = r_count[r_sel];
    assign w_idx_inc = r_idx + bpq_pkg::CNT_W'(1);

    // Slot store ports
    assign w_we    = i_cmd.enq_commit | i_cmd.shift_write;
    assign w_waddr = i_cmd.enq_commit ? bpq_pkg::slot_addr(r_sel, w_tail)
                                      : bpq_pkg::slot_addr(r_sel, bpq_pkg::wrap_add(w_head, r_idx));
    assign w_wdata = i_cmd.enq_commit ? r_id : w_rdata;
    assign w_re    = i_cmd.pop_read | i_cmd.scan_read | i_cmd.shift_read;

    always_comb begin
        if (i_cmd.pop_read) begin
            w_raddr = bpq_pkg::slot_addr(r_sel, w_head);
        end else if (i_cmd.shift_read) begin
            w_raddr = bpq_pkg::slot_addr(r_sel, bpq_pkg::wrap_add(w_head, w_idx_inc));
        end else begin
            w_raddr = bpq_pkg::slot_addr(r_sel, bpq_pkg::wrap_add(w_head, r_idx));
        end
    end

    bpq_ram #(
        .WIDTH (4),
        .DEPTH (bpq_pkg::SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Idle thread id register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_id <= '0;
        end else if (i_cfg_we) begin
            r_idle_id <= i_cfg_data;
        end
    end

    // Capture the request and the working level
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req_type <= i_req_type;
            r_id       <= i_thread_id;
            r_lvl_ok   <= w_lvl_ok;
            r_sel      <= w_sel;
        end
    end

    // Scan position
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_idx <= '0;
        end else if (i_cmd.scan_next || i_cmd.shift_write) begin
            r_idx <= w_idx_inc;
        end
    end

    // Per-level ring pointers, counts and the ready map
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int l = 0; l < bpq_pkg::NUM_LEVELS; l++) begin
                r_head[l]  <= '0;
                r_tail[l]  <= '0;
                r_count[l] <= '0;
            end
            r_map <= '0;
        end else if (i_cmd.enq_commit) begin
            r_tail[r_sel]  <= bpq_pkg::wrap_add(w_tail, bpq_pkg::CNT_W'(1));
            r_count[r_sel] <= w_count + bpq_pkg::CNT_W'(1);
            r_map[r_sel]   <= 1'b1;
        end else if (i_cmd.pop_commit) begin
            r_head[r_sel]  <= bpq_pkg::wrap_add(w_head, bpq_pkg::CNT_W'(1));
            r_count[r_sel] <= w_count - bpq_pkg::CNT_W'(1);
            if (w_count == bpq_pkg::CNT_W'(1)) begin
                r_map[r_sel] <= 1'b0;
            end
        end else if (i_cmd.rm_commit) begin
            r_tail[r_sel]  <= bpq_pkg::wrap_add(w_tail, bpq_pkg::CNT_W'(bpq_pkg::LEVEL_DEPTH - 1));
            r_count[r_sel] <= w_count - bpq_pkg::CNT_W'(1);
            if (w_count == bpq_pkg::CNT_W'(1)) begin
                r_map[r_sel] <= 1'b0;
            end
        end
    end

    // Result fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_res_id  <= i_thread_id;
            r_res_lvl <= i_priority_req;
            r_res_st  <= bpq_pkg::ST_OK;
        end else begin
            if (i_cmd.pop_commit) begin
                r_res_id  <= w_rdata;
                r_res_lvl <= 5'(r_sel);
            end
            if (i_cmd.empty_res) begin
                r_res_id  <= r_idle_id;
                r_res_lvl <= '0;
                r_res_st  <= bpq_pkg::ST_EMPTY;
            end
            if (i_cmd.st_we) begin
                r_res_st <= i_cmd.st;
            end
        end
    end

    // Output register
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_id  <= r_res_id;
            r_out_lvl <= r_res_lvl;
            r_out_st  <= r_res_st;
            r_out_map <= 32'(r_map);
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_thread_id = r_out_id;
    assign o_out_priority  = r_out_lvl;
    assign o_status        = r_out_st;
    assign o_ready_map     = r_out_map;

    // Status toward the sequencer
    always_comb begin
        o_stat.req_type  = r_req_type;
        o_stat.lvl_ok    = r_lvl_ok;
        o_stat.full      = (w_count == bpq_pkg::CNT_W'(bpq_pkg::LEVEL_DEPTH));
        o_stat.empty     = (r_map == '0);
        o_stat.scan_end  = (r_idx == w_count);
        o_stat.match     = (w_rdata == r_id);
        o_stat.shift_end = ((bpq_pkg::CNT_W + 1)'(r_idx) + (bpq_pkg::CNT_W + 1)'(1)
                            >= (bpq_pkg::CNT_W + 1)'(w_count));
        o_stat.out_free  = w_out_free;
    end

endmodule

FILE: design/bpq_ctrl.sv
module bpq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  bpq_pkg::t_dp_stat i_stat,
    output logic              o_req_ready,
    output bpq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DECODE   = 8'b0000_0010,
        S_POP_DATA = 8'b0000_0100,
        S_SCAN_RD  = 8'b0000_1000,
        S_SCAN_CMP = 8'b0001_0000,
        S_SHIFT_RD = 8'b0010_0000,
        S_SHIFT_WR = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.st = bpq_pkg::ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load_req = 1'b1;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_stat.req_type)
                    bpq_pkg::REQ_ENQ: begin
                        if (!i_stat.lvl_ok || i_stat.full) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = bpq_pkg::ST_FULL;
                        end else begin
                            o_cmd.enq_commit = 1'b1;
                        end
                        n_state = S_DONE;
                    end
                    bpq_pkg::REQ_POP: begin
                        if (i_stat.empty) begin
                            o_cmd.empty_res = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.pop_read = 1'b1;
                            n_state = S_POP_DATA;
                        end
                    end
                    bpq_pkg::REQ_REM: begin
                        if (!i_stat.lvl_ok) begin
                            o_cmd.st_we = 1'b1;
                            o_cmd.st    = bpq_pkg::ST_NOTFOUND;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            n_state = S_SCAN_RD;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_POP_DATA: begin
                o_cmd.pop_commit = 1'b1;
                n_state = S_DONE;
            end
            S_SCAN_RD: begin
                if (i_stat.scan_end) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = bpq_pkg::ST_NOTFOUND;
                    n_state = S_DONE;
                end else begin
                    o_cmd.scan_read = 1'b1;
                    n_state = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                if (i_stat.match) begin
                    n_state = S_SHIFT_RD;
                end else begin
                    o_cmd.scan_next = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_stat.shift_end) begin
                    o_cmd.rm_commit = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.shift_read = 1'b1;
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.shift_write = 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/bpq_checker.sv
module bpq_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_req_valid,
    input  logic        i_req_ready,
    input  logic        i_rsp_valid,
    input  logic        i_rsp_ready,
    input  logic [3:0]  i_rsp_thread_id,
    input  logic [4:0]  i_rsp_priority,
    input  logic [1:0]  i_rsp_status,
    input  logic [31:0] i_rsp_map
);

    // Hold a stalled result
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid)
        else $error("result dropped while stalled");

    // Keep a stalled result unchanged
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=>
            $stable({i_rsp_thread_id, i_rsp_priority, i_rsp_status, i_rsp_map}))
        else $error("stalled result changed");

    // An empty pop only happens on an empty store
    a_empty_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_rsp_status == bpq_pkg::ST_EMPTY) |-> (i_rsp_map == '0))
        else $error("empty status with a non-empty ready map");

    // One request in flight: drop ready right after a request
    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while busy");

endmodule

bind bitmap_priority_ready_queue bpq_checker u_bpq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_req_valid     (i_req.valid),
    .i_req_ready     (i_req.ready),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_thread_id (o_rsp.out_thread_id),
    .i_rsp_priority  (o_rsp.out_priority),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_map       (o_rsp.ready_map)
);
